// ===== hw/rtl/psu_pkg.sv =====
// Package for the PNG scanline unfilter block: constants, types, predictors.
// Used by every module under hw/rtl; no dependencies.
`default_nettype none
package psu_pkg;
  localparam int MaxWidth = 4096;
  localparam int MaxBpp = 8;
  localparam int StoreDepth = MaxWidth * MaxBpp;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);

  localparam logic [2:0] FiltNone = 3'd0;
  localparam logic [2:0] FiltSub = 3'd1;
  localparam logic [2:0] FiltUp = 3'd2;
  localparam logic [2:0] FiltAvg = 3'd3;
  localparam logic [2:0] FiltPaeth = 3'd4;

  localparam logic [2:0] ModeGray = 3'd0;
  localparam logic [2:0] ModeRgb = 3'd2;
  localparam logic [2:0] ModeGrayA = 3'd4;
  localparam logic [2:0] ModeRgba = 3'd6;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrFilter = 2'd1;
  localparam logic [1:0] ErrMode = 2'd2;

  // one classified job handed from front to back
  typedef struct packed {
    logic [1:0] err;        // nonzero: error result, no row byte
    logic [7:0] data;
    logic [2:0] filt;
    logic [2:0] k;          // byte slot within pixel
    logic       has_left;   // i >= bpp
    logic       first_row;
    logic       start;      // clear history/assembly before use
    logic       emit;
    logic       last;
    logic [AddrW-1:0] addr;
    logic       addr_ok;
    logic [2:0] mode;
    logic       d16;
  } job_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic signed [10:0] p, pa, pb, pc;
    begin
      p = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
      pa = p - $signed({3'b0, a});
      pb = p - $signed({3'b0, b});
      pc = p - $signed({3'b0, c});
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) paeth = a;
      else if (pb <= pc) paeth = b;
      else paeth = c;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/psu_front.sv =====
// Front end: tracks row/byte position, checks filter and mode, issues jobs.
// Depends on psu_pkg.
`default_nettype none
module psu_front import psu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [12:0] image_width,
  input  wire logic [15:0] image_height,
  input  wire logic        sample_depth_16,
  input  wire logic [2:0]  color_mode,
  input  wire logic        acc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        image_start,
  output job_t             job,
  output logic             job_push
);
  logic [15:0] row_byte_index;
  logic [15:0] row_index;
  logic [2:0] filter_kind;
  logic expect_filter_byte, halted;
  logic [2:0] k;          // row_byte_index % bpp, tracked incrementally
  logic has_left;
  logic pend_start;       // clear of history still owed to back end

  logic [12:0] w;
  logic [15:0] h;
  logic [3:0] bpp;
  logic [2:0] ch;
  logic mode_ok;
  logic [16:0] row_len;
  logic [15:0] ri, rbi;
  logic [2:0] fk;
  logic ef, hl, ps;
  logic [2:0] kk;
  logic hleft;
  logic end_row;

  always_comb begin
    w = (image_width == 13'd0) ? 13'd1 : image_width;
    if (w > 13'(MaxWidth)) w = 13'(MaxWidth);
    h = (image_height == 16'd0) ? 16'd1 : image_height;
    mode_ok = 1'b1;
    ch = 3'd4;
    unique case (color_mode)
      ModeGray: ch = 3'd1;
      ModeRgb: ch = 3'd3;
      ModeGrayA: ch = 3'd2;
      ModeRgba: ch = 3'd4;
      default: mode_ok = 1'b0;
    endcase
    bpp = sample_depth_16 ? {ch, 1'b0} : {1'b0, ch};
    row_len = 17'(w) * 17'(bpp);
  end

  always_comb begin
    ri = image_start ? 16'd0 : row_index;
    rbi = image_start ? 16'd0 : row_byte_index;
    fk = image_start ? 3'd0 : filter_kind;
    ef = image_start | expect_filter_byte;
    hl = image_start ? 1'b0 : halted;
    ps = image_start | pend_start;
    kk = image_start ? 3'd0 : k;
    hleft = image_start ? 1'b0 : has_left;
    end_row = (17'(rbi) + 17'd1) >= row_len;

    job = '0;
    job.data = data_byte;
    job.filt = fk;
    job.k = kk;
    job.has_left = hleft;
    job.first_row = (ri == 16'd0);
    job.start = ps;
    job.emit = ({1'b0, kk} == bpp - 4'd1);
    job.last = end_row && ((17'(ri) + 17'd1) >= 17'(h));
    job.addr = rbi[AddrW-1:0];
    job.addr_ok = (17'(rbi) < 17'(StoreDepth));
    job.mode = color_mode;
    job.d16 = sample_depth_16;
    job_push = 1'b0;
    if (acc && !hl && ri < h) begin
      if (!mode_ok) begin
        job.err = ErrMode;
        job_push = 1'b1;
      end else if (ef) begin
        if (data_byte > 8'd4) begin
          job.err = ErrFilter;
          job_push = 1'b1;
        end
      end else begin
        job_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_index <= '0;
      row_index <= '0;
      filter_kind <= '0;
      expect_filter_byte <= 1'b1;
      halted <= 1'b0;
      k <= '0;
      has_left <= 1'b0;
      pend_start <= 1'b1;
    end else if (acc) begin
      row_byte_index <= rbi;
      row_index <= ri;
      filter_kind <= fk;
      expect_filter_byte <= ef;
      halted <= hl;
      k <= kk;
      has_left <= hleft;
      pend_start <= ps;
      if (!hl && ri < h) begin
        if (!mode_ok) begin
          halted <= 1'b1;
        end else if (ef) begin
          if (data_byte > 8'd4) halted <= 1'b1;
          else begin
            filter_kind <= data_byte[2:0];
            expect_filter_byte <= 1'b0;
          end
        end else begin
          pend_start <= 1'b0;
          if ({1'b0, kk} == bpp - 4'd1) begin
            k <= '0;
            has_left <= 1'b1;
          end else k <= kk + 3'd1;
          if (end_row) begin
            row_index <= ri + 16'd1;
            row_byte_index <= '0;
            expect_filter_byte <= 1'b1;
            k <= '0;
            has_left <= 1'b0;
          end else row_byte_index <= rbi + 16'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/psu_queue.sv =====
// Short FIFO of jobs between front and back end.
// Depends on psu_pkg.
`default_nettype none
module psu_queue import psu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      din,
  input  wire logic pop,
  output job_t      dout,
  output logic      not_empty,
  output logic      almost_full
);
  job_t mem [QDepth];
  logic [QAddrW-1:0] wp, rp;
  logic [QAddrW:0] cnt;

  assign dout = mem[rp];
  assign not_empty = cnt != '0;
  // keep room for one item in flight past the stall decision
  assign almost_full = cnt >= (QAddrW+1)'(QDepth - 1);

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (QAddrW+1)'(push) - (QAddrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/psu_back.sv =====
// Back end: reads the line store, reconstructs bytes, assembles RGBA results.
// Depends on psu_pkg.
`default_nettype none
module psu_back import psu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  job_t      qjob,
  input  wire logic q_ne,
  output logic      q_pop,
  output logic       valid,
  input  wire logic  stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic       last_pixel,
  output logic [1:0] error_code
);
  logic [7:0] store [StoreDepth];
  logic [7:0] left_history [MaxBpp];
  logic [7:0] upper_left_history [MaxBpp];
  logic [7:0] asm_b [MaxBpp];

  // stage 1: job with store read in flight
  job_t s1;
  logic s1_v;
  logic [7:0] rd;
  // bypass for a store write made at the edge that launched the read
  logic byp_v;
  logic [AddrW-1:0] byp_a;
  logic [7:0] byp_d;

  logic [7:0] up, lf, ul, pred, recon;
  logic [8:0] sum;
  logic [7:0] ab [MaxBpp];
  logic s1_go;
  logic s1_res;
  logic [1:0] step;

  assign s1_res = (s1.err != ErrNone) || s1.emit;
  assign s1_go = s1_v && !(valid && stall && s1_res);
  assign q_pop = q_ne && (!s1_v || s1_go);

  always_ff @(posedge clk) begin
    if (q_pop) rd <= store[qjob.addr];
  end

  always_comb begin
    up = (s1.first_row || !s1.addr_ok) ? 8'd0 :
         (byp_v && byp_a == s1.addr) ? byp_d : rd;
    lf = (s1.has_left && !s1.start) ? left_history[s1.k] : 8'd0;
    ul = (s1.has_left && !s1.start) ? upper_left_history[s1.k] : 8'd0;
    sum = {1'b0, lf} + {1'b0, up};
    case (s1.filt)
      FiltSub: pred = lf;
      FiltUp: pred = up;
      FiltAvg: pred = sum[8:1];
      FiltPaeth: pred = paeth(lf, up, ul);
      default: pred = 8'd0;
    endcase
    recon = s1.data + pred;
    for (int n = 0; n < MaxBpp; n++) begin
      ab[n] = s1.start ? 8'd0 : asm_b[n];
    end
    ab[s1.k] = recon;
    step = s1.d16 ? 2'd2 : 2'd1;
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.err == ErrNone && s1.addr_ok) store[s1.addr] <= recon;
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.err == ErrNone) begin
      for (int n = 0; n < MaxBpp; n++) begin
        asm_b[n] <= ab[n];
        if (s1.start) begin
          left_history[n] <= 8'd0;
          upper_left_history[n] <= 8'd0;
        end
      end
      left_history[s1.k] <= recon;
      upper_left_history[s1.k] <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      byp_v <= 1'b0;
      valid <= 1'b0;
    end else begin
      // capture only at a read launch; hold while the job waits
      if (q_pop) byp_v <= s1_go && s1.err == ErrNone && s1.addr_ok;
      if (q_pop) s1_v <= 1'b1;
      else if (s1_go) s1_v <= 1'b0;
      if (s1_go && s1_res) valid <= 1'b1;
      else if (!stall) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byp_a <= s1.addr;
      byp_d <= recon;
    end
    if (q_pop) s1 <= qjob;
    if (s1_go && s1_res) begin
      if (s1.err != ErrNone) begin
        red <= '0; green <= '0; blue <= '0; alpha <= '0;
        last_pixel <= 1'b0;
        error_code <= s1.err;
      end else begin
        error_code <= ErrNone;
        last_pixel <= s1.last;
        if (s1.mode == ModeRgba || s1.mode == ModeRgb) begin
          red <= ab[0];
          green <= ab[3'(step)];
          blue <= ab[3'(2 * step)];
          alpha <= (s1.mode == ModeRgba) ? ab[3'(3 * step)] : 8'd255;
        end else begin
          red <= ab[0];
          green <= ab[0];
          blue <= ab[0];
          alpha <= (s1.mode == ModeGrayA) ? ab[3'(step)] : 8'd255;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/png_scanline_unfilter_rgba.sv =====
// PNG scanline unfilter to 8-bit RGBA.
// Inputs: one inflated byte per item on valid/stall with image_start marking
// the first byte of an image (it is also that image's row-0 filter byte).
// Output: one RGBA item per completed pixel, or one error item (error_code 1
// bad filter type, 2 bad color mode) after which bytes are dropped until the
// next image_start. Bytes beyond the last row are dropped.
// Throughput: one byte per cycle while in_stall stays low. out_valid for a
// pixel rises after its last byte passes the job queue, the stage-1 register
// (queue pop with line-store read) and the output register.
// The front classifies bytes and tracks position; a four-entry job queue
// feeds the back end, which reads the 32K-byte line store (one read, one
// write port) and reconstructs. Input stall rises when the queue nears full,
// so a stalled receiver backs up through the queue to the input.
// Reset clears counters and marks histories for clearing at the next row byte;
// the line store has no reset value and is read only once written this image.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
`default_nettype none
module png_scanline_unfilter_rgba import psu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        image_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             last_pixel,
  output logic [1:0]       error_code
);
  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegDepth = 2'd2;
  localparam logic [1:0] RegMode = 2'd3;

  logic [12:0] image_width;
  logic [15:0] image_height;
  logic sample_depth_16;
  logic [2:0] color_mode;
  job_t fjob, qjob;
  logic push, pop, q_ne, q_af, acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd1;
      image_height <= 16'd1;
      sample_depth_16 <= 1'b0;
      color_mode <= ModeRgba;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegWidth: image_width <= cfg_data[12:0];
        RegHeight: image_height <= cfg_data;
        RegDepth: sample_depth_16 <= cfg_data[0];
        RegMode: color_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_af;
  assign acc = in_valid && !in_stall;

  psu_front u_front (
    .clk, .rst, .image_width, .image_height, .sample_depth_16, .color_mode,
    .acc, .data_byte, .image_start, .job(fjob), .job_push(push)
  );

  psu_queue u_queue (
    .clk, .rst, .push, .din(fjob), .pop, .dout(qjob), .not_empty(q_ne),
    .almost_full(q_af)
  );

  psu_back u_back (
    .clk, .rst, .qjob, .q_ne, .q_pop(pop), .valid(out_valid), .stall(out_stall),
    .red, .green, .blue, .alpha, .last_pixel, .error_code
  );
endmodule
`default_nettype wire

// ===== tb/tb_png_scanline_unfilter_rgba.sv =====
// Testbench for png_scanline_unfilter_rgba: drives image bytes, predicts RGBA pixels
// with its own unfilter model and checks every output item in order.
// Depends on psu_pkg and the RTL top only.
`timescale 1ns / 1ps
module tb_png_scanline_unfilter_rgba;
  import psu_pkg::*;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegDepth = 2'd2;
  localparam logic [1:0] RegMode = 2'd3;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int Drain = 12;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
    logic [1:0] err;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic image_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue, alpha;
  logic last_pixel;
  logic [1:0] error_code;

  png_scanline_unfilter_rgba u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .image_start(image_start), .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .alpha(alpha), .last_pixel(last_pixel),
    .error_code(error_code)
  );

  always #2 clk = ~clk;

  // predictor state
  int px_width = 1, px_height = 1, depth16 = 0;
  logic [2:0] cmode = ModeRgba;
  logic [7:0] line_mem [StoreDepth];
  logic [7:0] left_hist [8];
  logic [7:0] upleft_hist [8];
  logic [7:0] pix_bytes [8];
  int byte_idx, row_idx;
  logic [2:0] filt;
  logic want_filter, halted;

  pixel_t want_q[$];
  int fails = 0;
  int sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  function automatic logic [7:0] paeth_pick(input int a, input int b, input int c);
    int p, pa, pb, pc;
    begin
      p = a + b - c;
      pa = (p > a) ? p - a : a - p;
      pb = (p > b) ? p - b : b - p;
      pc = (p > c) ? p - c : c - p;
      if (pa <= pb && pa <= pc) return a[7:0];
      if (pb <= pc) return b[7:0];
      return c[7:0];
    end
  endfunction

  function automatic int bytes_per_pixel(input logic [2:0] m, input int d16);
    int ch;
    begin
      case (m)
        ModeGray: ch = 1;
        ModeRgb: ch = 3;
        ModeGrayA: ch = 2;
        default: ch = 4;
      endcase
      return ch << d16;
    end
  endfunction

  task automatic clear_image();
    for (int n = 0; n < 8; n++) begin
      left_hist[n] = '0;
      upleft_hist[n] = '0;
      pix_bytes[n] = '0;
    end
    byte_idx = 0;
    row_idx = 0;
    filt = FiltNone;
    want_filter = 1'b1;
    halted = 1'b0;
  endtask

  // unfilter one accepted byte and queue the pixel it completes, if any
  task automatic unfilter_byte(input logic [7:0] d, input logic s);
    int w, h, bpp, i, k, st;
    logic [7:0] lft, up, ul, pred, recon;
    logic end_row;
    pixel_t px;
    begin
      if (s) clear_image();
      if (halted) return;
      w = (px_width == 0) ? 1 : (px_width > MaxWidth ? MaxWidth : px_width);
      h = (px_height == 0) ? 1 : px_height;
      if (row_idx >= h) return;
      px = '0;
      if (!(cmode inside {ModeGray, ModeRgb, ModeGrayA, ModeRgba})) begin
        halted = 1'b1;
        px.err = ErrMode;
        want_q.push_back(px);
        return;
      end
      bpp = bytes_per_pixel(cmode, depth16);
      if (want_filter) begin
        if (d > FiltPaeth) begin
          halted = 1'b1;
          px.err = ErrFilter;
          want_q.push_back(px);
          return;
        end
        filt = d[2:0];
        want_filter = 1'b0;
        return;
      end
      i = byte_idx;
      k = i % bpp;
      lft = (i >= bpp) ? left_hist[k] : 8'd0;
      up = (row_idx == 0 || i >= StoreDepth) ? 8'd0 : line_mem[i];
      ul = (i >= bpp) ? upleft_hist[k] : 8'd0;
      case (filt)
        FiltSub: pred = lft;
        FiltUp: pred = up;
        FiltAvg: pred = 8'((int'(lft) + int'(up)) >> 1);
        FiltPaeth: pred = paeth_pick(lft, up, ul);
        default: pred = 8'd0;
      endcase
      recon = d + pred;
      if (i < StoreDepth) line_mem[i] = recon;
      left_hist[k] = recon;
      upleft_hist[k] = up;
      pix_bytes[k] = recon;
      end_row = (i + 1) >= w * bpp;
      px.last = end_row && (row_idx + 1 >= h);
      if (end_row) begin
        row_idx++;
        byte_idx = 0;
        want_filter = 1'b1;
      end else begin
        byte_idx++;
      end
      if (k != bpp - 1) return;
      st = depth16 ? 2 : 1;
      if (cmode == ModeRgba || cmode == ModeRgb) begin
        px.r = pix_bytes[0];
        px.g = pix_bytes[st];
        px.b = pix_bytes[2 * st];
        px.a = (cmode == ModeRgba) ? pix_bytes[3 * st] : 8'd255;
      end else begin
        px.r = pix_bytes[0];
        px.g = pix_bytes[0];
        px.b = pix_bytes[0];
        px.a = (cmode == ModeGrayA) ? pix_bytes[st] : 8'd255;
      end
      px.err = ErrNone;
      want_q.push_back(px);
    end
  endtask

  // send one item; in_valid stays high afterwards for the next call
  task automatic send_byte(input logic [7:0] d, input logic s);
    logic stl;
    begin
      while (idle_on && $urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= d;
      image_start <= s;
      do begin
        @(negedge clk);
        stl = in_stall;
        @(posedge clk);
      end while (stl);
      unfilter_byte(d, s);
      sent++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegWidth: px_width = val & 16'h1fff;
      RegHeight: px_height = val & 16'hffff;
      RegDepth: depth16 = val & 1;
      default: cmode = val[2:0];
    endcase
  endtask

  task automatic setup(input int w, input int h, input int d16, input logic [2:0] m);
    drain();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegDepth, d16);
    write_reg(RegMode, m);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // send rows of the configured image; filter -1 picks a random good one
  task automatic send_image(input int rows, input int row_len, input int filter,
                            input int bad_pct);
    logic [7:0] f;
    begin
      for (int r = 0; r < rows; r++) begin
        if ($urandom_range(99) < bad_pct) f = 8'($urandom_range(255, 5));
        else if (filter < 0) f = 8'($urandom_range(4));
        else f = 8'(filter);
        send_byte(f, r == 0);
        for (int n = 0; n < row_len; n++) send_byte(pick_byte(), 1'b0);
      end
    end
  endtask

  function automatic int row_len_now();
    int w;
    begin
      w = (px_width == 0) ? 1 : (px_width > MaxWidth ? MaxWidth : px_width);
      return w * bytes_per_pixel(cmode, depth16);
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // output side: random stall, long hold on request, compare each item
  int hold_left = 0;
  always begin
    pixel_t got, want;
    logic took;
    @(negedge clk);
    took = out_valid && !out_stall;
    got = '{red, green, blue, alpha, last_pixel, error_code};
    @(posedge clk);
    if (took && !rst) begin
      if (want_q.size() == 0) begin
        $display("%0t unexpected item: actual %p", $time, got);
        fails++;
      end else begin
        want = want_q.pop_front();
        check_field("red", want.r, got.r);
        check_field("green", want.g, got.g);
        check_field("blue", want.b, got.b);
        check_field("alpha", want.a, got.a);
        check_field("last_pixel", want.last, got.last);
        check_field("error_code", want.err, got.err);
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 35);
    end
  end

  int quiet = 0;
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    // reset config: one RGBA pixel per image
    send_image(1, 4, FiltNone, 0);
    send_image(1, 4, FiltPaeth, 0);
  endtask

  task automatic test_filters();
    setup(3, 5, 0, ModeRgba);
    for (int f = FiltNone; f <= FiltPaeth; f++) begin
      send_byte(8'(f), f == FiltNone);
      for (int n = 0; n < 12; n++) send_byte((n % 2) ? 8'hff : 8'h00, 1'b0);
    end
  endtask

  task automatic test_modes();
    logic [2:0] modes [4] = '{ModeGray, ModeRgb, ModeGrayA, ModeRgba};
    for (int d = 0; d < 2; d++)
      for (int m = 0; m < 4; m++) begin
        setup(2, 2, d, modes[m]);
        send_image(2, row_len_now(), -1, 0);
      end
  endtask

  task automatic test_errors();
    setup(2, 2, 0, ModeRgb);
    send_byte(8'd5, 1'b1);
    send_byte(8'd1, 1'b0);
    send_byte(8'hff, 1'b1);
    for (int m = 1; m < 8; m += 2) begin
      setup(2, 2, 1, 3'(m));
      send_byte(8'd0, 1'b1);
      send_byte(8'd7, 1'b0);
    end
  endtask

  task automatic test_size_limits();
    // zero width and height act as one; trailing bytes are dropped
    setup(0, 0, 0, ModeGray);
    send_image(1, 1, FiltSub, 0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    // oversize width clamps; send part of a row and restart
    setup(8191, 65535, 1, ModeRgba);
    send_image(1, 24, FiltAvg, 0);
    setup(4096, 2, 0, ModeGray);
    send_image(1, 16, FiltUp, 0);
  endtask

  task automatic test_backpressure();
    setup(4, 40, 0, ModeRgba);
    idle_on = 1'b0;
    hold_req = 1'b1;
    send_image(6, 16, -1, 0);
    idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    setup(5, 4, 1, ModeGrayA);
    send_image(4, row_len_now(), -1, 0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_images();
    logic [2:0] modes [4] = '{ModeGray, ModeRgb, ModeGrayA, ModeRgba};
    int rows, h, len;
    logic [2:0] m;
    while (sent < 1550) begin
      if ($urandom_range(19) == 0) m = 3'($urandom_range(3) * 2 + 1);
      else m = modes[$urandom_range(3)];
      h = $urandom_range(1, 4);
      if ($urandom_range(3) != 0)
        setup(($urandom_range(15) == 0) ? 40 : $urandom_range(1, 6), h,
              $urandom_range(1), m);
      h = (px_height == 0) ? 1 : px_height;
      len = row_len_now();
      rows = ($urandom_range(9) == 0) ? $urandom_range(1, h) : h;
      send_image(rows, len, -1, 3);
      // truncate the row or run past the image end at times
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(pick_byte(), 1'b0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    clear_image();
    @(posedge clk);
    test_reset_defaults();
    test_filters();
    test_modes();
    test_errors();
    test_size_limits();
    test_backpressure();
    test_no_idle();
    test_random_images();
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
